// ===== src/rsdz_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsdz_pkg
// Shared constants for the radial stick dead zone block: field widths, the
// dead zone reset value and the Q-format sizes of the rescale math.
// ----------------------------------------------------------------------------
package rsdz_pkg;

    // Stream field widths.
    localparam int FIELD_W        = 16;
    localparam int DZ_W           = 16;
    localparam int AXIS_BITS_DEF  = 16;

    // Dead zone reset value, about 0.2 of full scale in Q0.16.
    localparam logic [DZ_W-1:0] DZ_RESET = 16'd13107;

    // Fraction bits added before the square root (radius gets 8 of them).
    localparam int SQ_SHIFT = 16;

    // Magnitude in Q0.16 and its one-bit headroom for the value 1.0.
    localparam int NQ_FRAC = 16;
    localparam int NQ_W    = NQ_FRAC + 1;

    // Quotient bits of the final per-axis division.
    localparam int Q2_W = 16;

    // Output saturation limit.
    localparam logic [FIELD_W-1:0] OUT_MAX = 16'd32767;

endpackage : rsdz_pkg
`default_nettype wire

// ===== src/radial_stick_dead_zone.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radial_stick_dead_zone
// Radial dead zone with magnitude rescale for one analog stick, built as a
// fully pipelined datapath: squares, bit-per-stage square root, a restoring
// divider for the rescaled magnitude and one divider lane per axis.
// ----------------------------------------------------------------------------
// Pipeline: the square root takes AXIS_BITS + 8 stages, each divider 16 stages.
// Throughput: one request per cycle; the whole pipeline holds on a stall.
// Reset: aresetn (synchronous, active low) empties the pipeline and loads
//   the dead zone register with its default of 13107.
// ----------------------------------------------------------------------------
module radial_stick_dead_zone #(
    parameter int AXIS_BITS = rsdz_pkg::AXIS_BITS_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // Dead zone register write channel.
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [rsdz_pkg::DZ_W-1:0]            cfg_data,
    // Input stream. tdata: raw_x [15:0], raw_y [31:16].
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [2*rsdz_pkg::FIELD_W-1:0]       s_tdata,
    // Result stream. tdata: out_x [15:0], out_y [31:16].
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [2*rsdz_pkg::FIELD_W-1:0]       m_tdata,
    // tuser: inside_dead_zone [0].
    output logic                                 m_tuser
);
    import rsdz_pkg::*;

    localparam int A      = AXIS_BITS;
    localparam int FW     = A - 1;
    localparam int SW     = 2 * A;
    localparam int VW     = SW + SQ_SHIFT;
    localparam int RW     = VW / 2;
    localparam int DZFW   = DZ_W + FW;
    localparam int DZ2W   = 2 * DZFW;
    localparam int NW     = RW + 8;
    localparam int MXW    = A + NQ_W;
    localparam int N2W    = MXW + 8;
    localparam int P2W    = N2W - Q2_W;
    localparam int SIDE_W = 2 * A + 4;
    localparam int XNEG_B = 2 * A;
    localparam int SZ_B   = 2 * A + 2;
    localparam int IN_B   = 2 * A + 3;
    localparam int D1N    = NQ_FRAC;
    localparam int D2N    = Q2_W;

    // Full scale, 2^(A-1)-1, is all ones in A-1 bits.
    localparam logic [FW-1:0] FULL = {FW{1'b1}};

    logic adv;

    // ------------------------------------------------------------------
    // Dead zone register and its derived constants.
    // ------------------------------------------------------------------
    logic [DZ_W-1:0] dz_reg;
    logic [DZFW-1:0] dzf_reg;
    logic [NW-1:0]   den_reg;
    logic [DZ2W-1:0] dzf2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_reg <= DZ_RESET;
        end else if (cfg_valid) begin
            dz_reg <= cfg_data;
        end
    end

    // Products are registered: dzf and den from the register, dzf squared from dzf.
    always_ff @(posedge aclk) begin
        dzf_reg  <= DZFW'(dz_reg) * DZFW'(FULL);
        den_reg  <= NW'(17'h10000 - {1'b0, dz_reg}) * NW'(FULL);
        dzf2_reg <= DZ2W'(dzf_reg) * DZ2W'(dzf_reg);
    end

    // The whole pipeline moves whenever the output register can take data.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // Stage A: axis magnitudes and signs.
    // ------------------------------------------------------------------
    logic              a_vld_reg;
    logic [SIDE_W-1:0] a_side_reg;
    logic [A-1:0]      in_x;
    logic [A-1:0]      in_y;
    logic [SIDE_W-1:0] a_side_next;

    always_comb begin
        in_x = s_tdata[A-1:0];
        in_y = s_tdata[FIELD_W +: A];
        a_side_next = '0;
        a_side_next[A-1:0]    = in_x[A-1] ? (~in_x + 1'b1) : in_x;
        a_side_next[2*A-1:A]  = in_y[A-1] ? (~in_y + 1'b1) : in_y;
        a_side_next[XNEG_B]   = in_x[A-1];
        a_side_next[XNEG_B+1] = in_y[A-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_side_reg <= a_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: squares of both axes.
    // ------------------------------------------------------------------
    logic              b_vld_reg;
    logic [SIDE_W-1:0] b_side_reg;
    logic [SW-1:0]     b_sqx_reg;
    logic [SW-1:0]     b_sqy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (adv) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_side_reg <= a_side_reg;
            b_sqx_reg  <= SW'(a_side_reg[A-1:0]) * SW'(a_side_reg[A-1:0]);
            b_sqy_reg  <= SW'(a_side_reg[2*A-1:A]) * SW'(a_side_reg[2*A-1:A]);
        end
    end

    // ------------------------------------------------------------------
    // Stage C: squared length.
    // ------------------------------------------------------------------
    logic              c_vld_reg;
    logic [SIDE_W-1:0] c_side_reg;
    logic [SW-1:0]     c_s_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (adv) begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_side_reg <= b_side_reg;
            c_s_reg    <= b_sqx_reg + b_sqy_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root stages, one root bit per stage. Entry stage also runs
    // the exact dead zone test and the zero vector check.
    // ------------------------------------------------------------------
    logic              sq_vld_reg  [0:RW];
    logic [SIDE_W-1:0] sq_side_reg [0:RW];
    logic [SW-1:0]     sq_s_reg    [0:RW];
    logic [RW-1:0]     sq_q_reg    [0:RW];
    logic [RW+1:0]     sq_rem_reg  [0:RW];
    logic [SW+31:0]    dz_lhs;
    logic              dz_inside;
    logic [SIDE_W-1:0] sq0_side;

    always_comb begin
        dz_lhs    = {c_s_reg, 32'd0};
        dz_inside = dz_lhs < (SW+32)'(dzf2_reg);
        sq0_side  = c_side_reg;
        sq0_side[IN_B] = dz_inside;
        sq0_side[SZ_B] = (c_s_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_vld_reg[0] <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_side_reg[0] <= sq0_side;
            sq_s_reg[0]    <= c_s_reg;
            sq_q_reg[0]    <= '0;
            sq_rem_reg[0]  <= '0;
        end
    end

    for (genvar i = 0; i < RW; i++) begin : g_sqrt
        localparam int K = RW - 1 - i;
        logic [VW-1:0] v;
        logic [RW+3:0] rs;
        logic [RW+3:0] tr;
        logic [RW+3:0] df;
        logic          take;

        // Bring down two radicand bits and try the next root bit.
        always_comb begin
            v    = {sq_s_reg[i], {SQ_SHIFT{1'b0}}};
            rs   = {sq_rem_reg[i], v[2*K+1 -: 2]};
            tr   = (RW+4)'({sq_q_reg[i], 2'b01});
            df   = rs - tr;
            take = rs >= tr;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                sq_vld_reg[i+1] <= sq_vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_side_reg[i+1] <= sq_side_reg[i];
                sq_s_reg[i+1]    <= sq_s_reg[i];
                sq_q_reg[i+1]    <= {sq_q_reg[i][RW-2:0], take};
                sq_rem_reg[i+1]  <= take ? df[RW+1:0] : rs[RW+1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Magnitude rescale: (R*256 - dzf) / den in Q0.16, clamped to 1.
    // ------------------------------------------------------------------
    logic              d1_vld_reg  [0:D1N];
    logic [SIDE_W-1:0] d1_side_reg [0:D1N];
    logic [RW-1:0]     d1_r_reg    [0:D1N];
    logic              d1_sat_reg  [0:D1N];
    logic [NW-1:0]     d1_p_reg    [0:D1N];
    logic [D1N-1:0]    d1_q_reg    [0:D1N];
    logic [NW-1:0]     r_scaled;
    logic [NW-1:0]     numer;
    logic              numer_sat;

    always_comb begin
        r_scaled  = {sq_q_reg[RW], 8'd0};
        numer     = (r_scaled > NW'(dzf_reg)) ? (r_scaled - NW'(dzf_reg)) : '0;
        numer_sat = numer >= den_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            d1_vld_reg[0] <= sq_vld_reg[RW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_side_reg[0] <= sq_side_reg[RW];
            d1_r_reg[0]    <= sq_q_reg[RW];
            d1_sat_reg[0]  <= numer_sat;
            d1_p_reg[0]    <= numer_sat ? '0 : numer;
            d1_q_reg[0]    <= '0;
        end
    end

    for (genvar j = 0; j < D1N; j++) begin : g_div1
        logic [NW:0] ps;
        logic [NW:0] dn;
        logic [NW:0] df;
        logic        take;

        always_comb begin
            ps   = {d1_p_reg[j], 1'b0};
            dn   = (NW+1)'(den_reg);
            df   = ps - dn;
            take = ps >= dn;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d1_vld_reg[j+1] <= 1'b0;
            end else if (adv) begin
                d1_vld_reg[j+1] <= d1_vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                d1_side_reg[j+1] <= d1_side_reg[j];
                d1_r_reg[j+1]    <= d1_r_reg[j];
                d1_sat_reg[j+1]  <= d1_sat_reg[j];
                d1_p_reg[j+1]    <= take ? df[NW-1:0] : ps[NW-1:0];
                d1_q_reg[j+1]    <= {d1_q_reg[j][D1N-2:0], take};
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage F: axis magnitude times rescaled length.
    // ------------------------------------------------------------------
    logic              f_vld_reg;
    logic [SIDE_W-1:0] f_side_reg;
    logic [RW-1:0]     f_r_reg;
    logic [MXW-1:0]    f_m_reg [0:1];
    logic [NQ_W-1:0]   nq;

    assign nq = d1_sat_reg[D1N] ? NQ_W'(17'h10000) : {1'b0, d1_q_reg[D1N]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else if (adv) begin
            f_vld_reg <= d1_vld_reg[D1N];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_side_reg <= d1_side_reg[D1N];
            f_r_reg    <= d1_r_reg[D1N];
            f_m_reg[0] <= MXW'(d1_side_reg[D1N][A-1:0]) * MXW'(nq);
            f_m_reg[1] <= MXW'(d1_side_reg[D1N][2*A-1:A]) * MXW'(nq);
        end
    end

    // ------------------------------------------------------------------
    // Per-axis rounded division (2m + R) / 2R, one quotient bit a stage.
    // ------------------------------------------------------------------
    logic              d2_vld_reg  [0:D2N];
    logic [SIDE_W-1:0] d2_side_reg [0:D2N];
    logic [RW:0]       d2_d_reg    [0:D2N];
    logic [P2W-1:0]    d2_p_reg    [0:1][0:D2N];
    logic [D2N-1:0]    d2_lo_reg   [0:1][0:D2N];
    logic [D2N-1:0]    d2_q_reg    [0:1][0:D2N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d2_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            d2_vld_reg[0] <= f_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d2_side_reg[0] <= f_side_reg;
            d2_d_reg[0]    <= {f_r_reg, 1'b0};
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [N2W-1:0] n2;

        // Dividend is 2m + R with m = |axis| * nq * 128.
        assign n2 = {f_m_reg[l], 8'd0} + N2W'(f_r_reg);

        always_ff @(posedge aclk) begin
            if (adv) begin
                d2_p_reg[l][0]  <= n2[N2W-1:D2N];
                d2_lo_reg[l][0] <= n2[D2N-1:0];
                d2_q_reg[l][0]  <= '0;
            end
        end

        for (genvar j = 0; j < D2N; j++) begin : g_div2
            logic [P2W:0] ps;
            logic [P2W:0] dn;
            logic [P2W:0] df;
            logic         take;

            always_comb begin
                ps   = {d2_p_reg[l][j], d2_lo_reg[l][j][D2N-1-j]};
                dn   = (P2W+1)'(d2_d_reg[j]);
                df   = ps - dn;
                take = ps >= dn;
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    d2_p_reg[l][j+1]  <= take ? df[P2W-1:0] : ps[P2W-1:0];
                    d2_lo_reg[l][j+1] <= d2_lo_reg[l][j];
                    d2_q_reg[l][j+1]  <= {d2_q_reg[l][j][D2N-2:0], take};
                end
            end
        end
    end

    for (genvar j = 0; j < D2N; j++) begin : g_div2_ctl
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d2_vld_reg[j+1] <= 1'b0;
            end else if (adv) begin
                d2_vld_reg[j+1] <= d2_vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                d2_side_reg[j+1] <= d2_side_reg[j];
                d2_d_reg[j+1]    <= d2_d_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: saturate, apply sign, force zero in the dead zone
    // and for the zero vector.
    // ------------------------------------------------------------------
    logic                 m_tvalid_reg;
    logic [2*FIELD_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic [2*FIELD_W-1:0] out_next;
    logic [FIELD_W-1:0]   mag [0:1];
    logic                 zero_out;

    always_comb begin
        zero_out = d2_side_reg[D2N][IN_B] || d2_side_reg[D2N][SZ_B];
        out_next = '0;
        for (int l = 0; l < 2; l++) begin
            mag[l] = (FIELD_W'(d2_q_reg[l][D2N]) > OUT_MAX) ? OUT_MAX
                     : FIELD_W'(d2_q_reg[l][D2N]);
            if (!zero_out) begin
                out_next[l*FIELD_W +: FIELD_W] =
                    d2_side_reg[D2N][XNEG_B+l] ? (~mag[l] + 1'b1) : mag[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= d2_vld_reg[D2N];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= out_next;
            m_tuser_reg <= d2_side_reg[D2N][IN_B];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule : radial_stick_dead_zone
`default_nettype wire
